### src/qv2dt_pkg.sv
// Shared types and constants for the quad vertex 2D transform core.
// Action codes, sequencer states, angle constants and the CORDIC arctangent table.
// No dependencies.
package qv2dt_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Stream payload widths
    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 5;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // Angle handling, units of 1/64 degree
    localparam int ANGLE_W = 17;
    localparam logic signed [ANGLE_W-1:0] TURN_FULL    = 17'sd23040;
    localparam logic signed [ANGLE_W-1:0] TURN_HALF    = 17'sd11520;
    localparam logic signed [ANGLE_W-1:0] TURN_QUARTER = 17'sd5760;

    // CORDIC datapath, Q1.14 trig values, angle in 2^-16 degree
    localparam int TRIG_W = 18;
    localparam int Z_W    = 28;
    localparam int ATAN_W = 22;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 18'sd9949;

    typedef enum logic [2:0] {
        ACT_LOAD      = 3'd0,
        ACT_TRANSLATE = 3'd1,
        ACT_SCALE     = 3'd2,
        ACT_ROTATE    = 3'd3,
        ACT_READ      = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_CORDIC,
        ST_PROD,
        ST_WRITE,
        ST_EMIT
    } state_t;

    // atan(2^-i) in degrees scaled by 65536
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] step);
        logic [ATAN_W-1:0] val;
        case (step)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

### src/quad_vertex_2d_transform_core.sv
// Quad vertex 2D transform core: four stored corners, load/translate/scale/rotate/read.
// One shared multiplier and a shared CORDIC shift/add unit run under a small sequencer.
// Depends on qv2dt_pkg.
// Load writes one corner and stays ready. Read goes straight to the output beats, translate
// writes each corner in turn, scale takes two products per corner, rotate runs angle setup
// and the CORDIC iterations first. All but load then give 4 output beats, with tready low
// from accept until the fourth beat is taken. Rotate time is set by the CORDIC iterations plus
// four products per corner through the single multiplier. Reset is asynchronous, active low,
// and restores the square corners (100,100),(200,100),(200,200),(100,200).
module quad_vertex_2d_transform_core
    import qv2dt_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // load_x, load_y, shift_x, shift_y, factor_x, factor_y, turn_angle (16 bits each)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[2:0], vertex_index[4:3]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_x, out_y (16 bits each)
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // out_index
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = DW + TRIG_W;
    localparam int AW = PW + 1;
    localparam int EW = (CW > 16) ? CW : 16;
    localparam int SW = $clog2(CORDIC_STEPS);

    localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[CW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // divide by 2^sh, truncating toward zero
    function automatic logic signed [AW-1:0] trunc_shift(input logic signed [AW-1:0] v,
                                                         input int sh);
        logic signed [AW-1:0] bias;
        bias = v[AW-1] ? ((AW'(1) << sh) - AW'(1)) : '0;
        return (v + bias) >>> sh;
    endfunction

    state_t                  state_reg, state_next;
    logic signed [CW-1:0]    corner_x_reg [4];
    logic signed [CW-1:0]    corner_x_next [4];
    logic signed [CW-1:0]    corner_y_reg [4];
    logic signed [CW-1:0]    corner_y_next [4];
    logic [1:0]              idx_reg, idx_next;
    logic [2:0]              step_reg, step_next;
    logic [SW-1:0]           cstep_reg, cstep_next;

    logic [2:0]              act_reg, act_next;
    logic signed [15:0]      opa_reg, opa_next;
    logic signed [15:0]      opb_reg, opb_next;
    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    flip_reg, flip_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [AW-1:0]    accx_reg, accx_next;
    logic signed [AW-1:0]    accy_reg, accy_next;

    // Input fields
    logic [2:0]              in_action;
    logic [1:0]              in_vidx;
    logic signed [15:0]      in_load_x, in_load_y, in_shift_x, in_shift_y;
    logic signed [15:0]      in_factor_x, in_factor_y, in_angle;

    assign in_action   = s_axis_tuser[2:0];
    assign in_vidx     = s_axis_tuser[4:3];
    assign in_load_x   = s_axis_tdata[15:0];
    assign in_load_y   = s_axis_tdata[31:16];
    assign in_shift_x  = s_axis_tdata[47:32];
    assign in_shift_y  = s_axis_tdata[63:48];
    assign in_factor_x = s_axis_tdata[79:64];
    assign in_factor_y = s_axis_tdata[95:80];
    assign in_angle    = s_axis_tdata[111:96];

    // Angle reduction into [-half, half), then fold into +-quarter turn
    logic signed [ANGLE_W-1:0] ang_full, ang_red, ang_fold;
    logic                      ang_flip;
    logic signed [Z_W-1:0]     z_init;
    logic signed [CW:0]        csum_x, csum_y, cadj_x, cadj_y;

    always_comb
    begin
        ang_full = ANGLE_W'(opa_reg);
        if (ang_full >= TURN_HALF)
        begin
            ang_red = ang_full - TURN_FULL;
        end
        else if (ang_full < -TURN_HALF)
        begin
            ang_red = ang_full + TURN_FULL;
        end
        else
        begin
            ang_red = ang_full;
        end
        ang_flip = 1'b1;
        if (ang_red > TURN_QUARTER)
        begin
            ang_fold = ang_red - TURN_HALF;
        end
        else if (ang_red < -TURN_QUARTER)
        begin
            ang_fold = ang_red + TURN_HALF;
        end
        else
        begin
            ang_fold = ang_red;
            ang_flip = 1'b0;
        end
        z_init = {{(Z_W-ANGLE_W-10){ang_fold[ANGLE_W-1]}}, ang_fold, 10'b0};

        // center, halved toward zero
        csum_x = DW'(corner_x_reg[0]) + DW'(corner_x_reg[2]);
        csum_y = DW'(corner_y_reg[0]) + DW'(corner_y_reg[2]);
        cadj_x = csum_x + {{CW{1'b0}}, csum_x[CW]};
        cadj_y = csum_y + {{CW{1'b0}}, csum_y[CW]};
    end

    // CORDIC micro-rotation, shared shifter indexed by the step counter
    logic signed [TRIG_W-1:0] cord_xs, cord_ys, cord_x, cord_y;
    logic signed [Z_W-1:0]    cord_atan, cord_z;

    always_comb
    begin
        cord_xs   = cos_reg >>> cstep_reg;
        cord_ys   = sin_reg >>> cstep_reg;
        cord_atan = Z_W'(atan_lut(5'(cstep_reg)));
        if (!z_reg[Z_W-1])
        begin
            cord_x = cos_reg - cord_ys;
            cord_y = sin_reg + cord_xs;
            cord_z = z_reg - cord_atan;
        end
        else
        begin
            cord_x = cos_reg + cord_ys;
            cord_y = sin_reg - cord_xs;
            cord_z = z_reg + cord_atan;
        end
    end

    // Shared multiplier operand select
    logic signed [DW-1:0]     cur_x, cur_y, dx, dy;
    logic signed [DW-1:0]     mul_a;
    logic signed [TRIG_W-1:0] mul_b;
    logic                     is_rot;
    logic [2:0]               last_step;

    always_comb
    begin
        cur_x     = DW'(corner_x_reg[idx_reg]);
        cur_y     = DW'(corner_y_reg[idx_reg]);
        dx        = cur_x - DW'(cx_reg);
        dy        = cur_y - DW'(cy_reg);
        is_rot    = (act_reg == ACT_ROTATE);
        last_step = is_rot ? 3'd4 : 3'd2;
        if (is_rot)
        begin
            case (step_reg)
                3'd0:    begin mul_a = dx; mul_b = cos_reg; end
                3'd1:    begin mul_a = dy; mul_b = sin_reg; end
                3'd2:    begin mul_a = dx; mul_b = sin_reg; end
                default: begin mul_a = dy; mul_b = cos_reg; end
            endcase
        end
        else
        begin
            case (step_reg)
                3'd0:    begin mul_a = cur_x; mul_b = TRIG_W'(opa_reg); end
                default: begin mul_a = cur_y; mul_b = TRIG_W'(opb_reg); end
            endcase
        end
    end

    // New corner value for the write-back cycle
    logic signed [CW-1:0] new_x, new_y;

    always_comb
    begin
        case (act_reg)
            ACT_TRANSLATE:
            begin
                new_x = sat(AW'(corner_x_reg[idx_reg]) + AW'(opa_reg));
                new_y = sat(AW'(corner_y_reg[idx_reg]) + AW'(opb_reg));
            end
            ACT_SCALE:
            begin
                new_x = sat(trunc_shift(accx_reg, 8));
                new_y = sat(trunc_shift(accy_reg, 8));
            end
            default:
            begin
                new_x = sat(trunc_shift(accx_reg, 14) + AW'(cx_reg));
                new_y = sat(trunc_shift(accy_reg, 14) + AW'(cy_reg));
            end
        endcase
    end

    // Sequencer: next state, datapath updates and handshake outputs
    logic signed [EW-1:0] out_x_ext, out_y_ext;

    always_comb
    begin
        state_next    = state_reg;
        corner_x_next = corner_x_reg;
        corner_y_next = corner_y_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        cstep_next    = cstep_reg;
        act_next      = act_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cos_next      = cos_reg;
        sin_next      = sin_reg;
        z_next        = z_reg;
        flip_next     = flip_reg;
        prod_next     = mul_a * mul_b;
        accx_next     = accx_reg;
        accy_next     = accy_reg;

        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        out_x_ext     = EW'(corner_x_reg[idx_reg]);
        out_y_ext     = EW'(corner_y_reg[idx_reg]);
        m_axis_tdata  = {out_y_ext[15:0], out_x_ext[15:0]};
        m_axis_tuser  = idx_reg;
        m_axis_tlast  = (idx_reg == 2'd3);

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    act_next  = in_action;
                    idx_next  = 2'd0;
                    step_next = 3'd0;
                    case (in_action)
                        ACT_LOAD:
                        begin
                            corner_x_next[in_vidx] = sat(AW'(in_load_x));
                            corner_y_next[in_vidx] = sat(AW'(in_load_y));
                        end
                        ACT_TRANSLATE:
                        begin
                            opa_next   = in_shift_x;
                            opb_next   = in_shift_y;
                            state_next = ST_WRITE;
                        end
                        ACT_SCALE:
                        begin
                            opa_next   = in_factor_x;
                            opb_next   = in_factor_y;
                            state_next = ST_PROD;
                        end
                        ACT_ROTATE:
                        begin
                            opa_next   = in_angle;
                            state_next = ST_ANGLE;
                        end
                        ACT_READ:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ANGLE:
            begin
                cos_next   = CORDIC_GAIN;
                sin_next   = '0;
                z_next     = z_init;
                flip_next  = ang_flip;
                cx_next    = cadj_x[CW:1];
                cy_next    = cadj_y[CW:1];
                cstep_next = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cos_next = cord_x;
                sin_next = cord_y;
                z_next   = cord_z;
                if (cstep_reg == SW'(CORDIC_STEPS - 1))
                begin
                    // quadrant fold: both sine and cosine change sign
                    if (flip_reg)
                    begin
                        cos_next = -cord_x;
                        sin_next = -cord_y;
                    end
                    state_next = ST_PROD;
                end
                else
                begin
                    cstep_next = cstep_reg + SW'(1);
                end
            end
            ST_PROD:
            begin
                // product issued at step k is accumulated at step k+1
                if (is_rot)
                begin
                    case (step_reg)
                        3'd1:    accx_next = AW'(prod_reg);
                        3'd2:    accx_next = accx_reg - AW'(prod_reg);
                        3'd3:    accy_next = AW'(prod_reg);
                        3'd4:    accy_next = accy_reg + AW'(prod_reg);
                        default: accx_next = accx_reg;
                    endcase
                end
                else
                begin
                    case (step_reg)
                        3'd1:    accx_next = AW'(prod_reg);
                        3'd2:    accy_next = AW'(prod_reg);
                        default: accx_next = accx_reg;
                    endcase
                end
                if (step_reg == last_step)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_WRITE:
            begin
                corner_x_next[idx_reg] = new_x;
                corner_y_next[idx_reg] = new_y;
                step_next              = 3'd0;
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = (act_reg == ACT_TRANSLATE) ? ST_WRITE : ST_PROD;
                end
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= 2'd0;
            step_reg        <= 3'd0;
            cstep_reg       <= '0;
            corner_x_reg[0] <= CW'(100);
            corner_x_reg[1] <= CW'(200);
            corner_x_reg[2] <= CW'(200);
            corner_x_reg[3] <= CW'(100);
            corner_y_reg[0] <= CW'(100);
            corner_y_reg[1] <= CW'(100);
            corner_y_reg[2] <= CW'(200);
            corner_y_reg[3] <= CW'(200);
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            cstep_reg    <= cstep_next;
            corner_x_reg <= corner_x_next;
            corner_y_reg <= corner_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        prod_reg <= prod_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
    end

    // Input and output sides are never open in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while results pending");

    // Final beat of a run frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after last beat");

    // A read starts reporting at corner 0 on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[2:0] == ACT_READ)
        |=> (m_axis_tvalid && m_axis_tuser == 2'd0))
        else $error("read did not start at corner 0");

    // A load produces no beat and leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[2:0] == ACT_LOAD)
        |=> (s_axis_tready && !m_axis_tvalid))
        else $error("load did not return to ready");

    // Rotation goes through angle setup into the CORDIC run
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[2:0] == ACT_ROTATE)
        |=> (state_reg == ST_ANGLE) ##1 (state_reg == ST_CORDIC))
        else $error("rotate sequence broken");

endmodule
